>>> hw/rtl/rtp_pkg.sv
package rtp_pkg;

	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_AMP      = 8'h26;
	localparam logic [7:0] CH_EQUALS   = 8'h3D;
	localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

	localparam int MAX_RESULTS = 4;
	localparam int GRP_DEPTH   = 2;

	typedef enum logic [2:0] {
		PH_START      = 3'd0,
		PH_PATH_FRESH = 3'd1,
		PH_PATH_OPEN  = 3'd2,
		PH_KEY_FRESH  = 3'd3,
		PH_KEY_OPEN   = 3'd4,
		PH_VALUE      = 3'd5,
		PH_SKIP       = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		EV_DATA     = 3'd0,
		EV_SEG_END  = 3'd1,
		EV_KEY_END  = 3'd2,
		EV_PAIR_END = 3'd3,
		EV_ACCEPT   = 3'd4,
		EV_ERROR    = 3'd5
	} ev_t;

	localparam logic [1:0] PART_PATH  = 2'd0;
	localparam logic [1:0] PART_KEY   = 2'd1;
	localparam logic [1:0] PART_VALUE = 2'd2;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_SLASH  = 2'd1;
	localparam logic [1:0] ERR_ESCAPE = 2'd2;

	localparam logic [1:0] ESC_IDLE = 2'd0;
	localparam logic [1:0] ESC_HIGH = 2'd1;
	localparam logic [1:0] ESC_LOW  = 2'd2;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] esc;
		logic [3:0] hi;
	} parse_state_t;

	localparam parse_state_t ST_RESET = '{phase: PH_START, esc: ESC_IDLE, hi: 4'd0};

	typedef struct packed {
		ev_t        ev;
		logic [7:0] data;
		logic [1:0] part;
		logic [1:0] err;
	} result_t;

	typedef struct packed {
		logic [2:0]    cnt;
		result_t [3:0] res;
	} group_t;

	// {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			r = {1'b1, c[3:0] - 4'd1 + HEX_LETTER_BASE};
		return r;
	endfunction

	function automatic logic [1:0] part_of(input phase_t ph);
		logic [1:0] p;
		p = PART_PATH;
		if (ph == PH_KEY_FRESH || ph == PH_KEY_OPEN)
			p = PART_KEY;
		else if (ph == PH_VALUE)
			p = PART_VALUE;
		return p;
	endfunction

	function automatic result_t mk(input ev_t ev, input logic [7:0] data,
		input logic [1:0] part, input logic [1:0] err);
		result_t r;
		r.ev   = ev;
		r.data = data;
		r.part = part;
		r.err  = err;
		return r;
	endfunction

endpackage

>>> hw/rtl/rtp_in_if.sv
interface rtp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] target_byte;
	logic       final_byte;

	modport source(output valid, output target_byte, output final_byte, input ready);
	modport sink(input valid, input target_byte, input final_byte, output ready);
endinterface

>>> hw/rtl/rtp_out_if.sv
interface rtp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] decoded_byte;
	logic [1:0] part;
	logic [1:0] error_kind;
	logic       run_last;

	modport source(output valid, output event_res, output decoded_byte, output part,
		output error_kind, output run_last, input ready);
	modport sink(input valid, input event_res, input decoded_byte, input part,
		input error_kind, input run_last, output ready);
endinterface

>>> hw/rtl/request_target_parser_core.sv
// Request target parser with percent decoding.
// target: one raw byte of the request target per item, final_byte marks the
//   last byte. The path is split at slashes, the query at ampersands and
//   equals signs, and percent escapes are decoded.
// events: decoded bytes, segment/key/pair ends, then accept or error;
//   run_last marks the last result that one input byte caused.
// Each accepted byte is parsed in the cycle it is taken; its results, if
//   any (up to four), go as one group into a two-entry result queue and
//   are offered in order, one result per cycle while events ready is high.
// Throughput: one byte per cycle while each byte yields at most one
//   result and events ready is high; a byte with more results holds the
//   output until all are taken; the rate is set by the single result port.
// When the receiver stalls, the queue holds up to two groups and target
//   ready drops only when both entries are full.
// Reset empties the queue and leaves the parser waiting for a leading slash.
// After an error, bytes are dropped without results up to and including the
//   byte flagged final.
module request_target_parser_core
	import rtp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	rtp_in_if.sink     target,
	rtp_out_if.source  events
);

	parse_state_t state_q;
	parse_state_t state_n;
	group_t       grp;
	group_t       grp_q [GRP_DEPTH];
	logic [1:0]   cnt_q;
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   idx_q;
	logic         acc;
	logic         push;
	logic         pop;
	logic         last_res;
	group_t       head;
	result_t      cur;

	rtp_decode u_decode (
		.st   (state_q),
		.b    (target.target_byte),
		.fin  (target.final_byte),
		.st_n (state_n),
		.grp  (grp)
	);

	assign target.ready = (cnt_q != 2'(GRP_DEPTH));
	assign acc          = target.valid && target.ready;
	assign push         = acc && (grp.cnt != 3'd0);

	assign head     = grp_q[rd_q];
	assign cur      = head.res[idx_q];
	assign last_res = ({1'b0, idx_q} == (head.cnt - 3'd1));
	assign pop      = events.valid && events.ready && last_res;

	assign events.valid        = (cnt_q != 2'd0);
	assign events.event_res    = cur.ev;
	assign events.decoded_byte = cur.data;
	assign events.part         = cur.part;
	assign events.error_kind   = cur.err;
	assign events.run_last     = last_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RESET;
			cnt_q   <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (acc)
				state_q <= state_n;
			if (push)
				wr_q <= ~wr_q;
			if (pop) begin
				rd_q  <= ~rd_q;
				idx_q <= 2'd0;
			end else if (events.valid && events.ready) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			grp_q[wr_q] <= grp;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(GRP_DEPTH))
		else $error("result queue overflow");

	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> (head.cnt != 3'd0 && {1'b0, idx_q} < head.cnt))
		else $error("queued group has no result at current index");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && state_q.phase == PH_SKIP) |-> !push)
		else $error("result produced while skipping after error");

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && target.final_byte) |=> (state_q == ST_RESET))
		else $error("parser state not cleared after final byte");
`endif

endmodule

>>> hw/rtl/rtp_decode.sv
module rtp_decode
	import rtp_pkg::*;
(
	input  parse_state_t st,
	input  logic [7:0]   b,
	input  logic         fin,
	output parse_state_t st_n,
	output group_t       grp
);

	logic [2:0]    n;
	result_t [3:0] res;
	logic          do_fin;
	logic [4:0]    hv;

	always_comb begin
		st_n   = st;
		n      = 3'd0;
		res    = '0;
		do_fin = 1'b0;
		hv     = hex_val(b);

		if (st.phase == PH_SKIP) begin
			if (fin)
				st_n = ST_RESET;
		end else if (st.phase == PH_START || st.phase > PH_VALUE) begin
			st_n = ST_RESET;
			if (b != CH_SLASH) begin
				res[n[1:0]] = mk(EV_ERROR, 8'd0, PART_PATH, ERR_SLASH);
				n = n + 3'd1;
				if (!fin)
					st_n.phase = PH_SKIP;
			end else begin
				st_n.phase = PH_PATH_FRESH;
				do_fin = fin;
			end
		end else if (st.esc != ESC_IDLE) begin
			if (!hv[4]) begin
				res[n[1:0]] = mk(EV_ERROR, 8'd0, PART_PATH, ERR_ESCAPE);
				n = n + 3'd1;
				st_n = ST_RESET;
				if (!fin)
					st_n.phase = PH_SKIP;
			end else if (st.esc == ESC_HIGH) begin
				st_n.hi  = hv[3:0];
				st_n.esc = ESC_LOW;
				do_fin = fin;
			end else begin
				res[n[1:0]] = mk(EV_DATA, {st.hi, hv[3:0]}, part_of(st.phase), ERR_NONE);
				n = n + 3'd1;
				st_n.esc = ESC_IDLE;
				st_n.hi  = 4'd0;
				do_fin = fin;
			end
		end else begin
			do_fin = fin;
			case (st.phase)
				PH_PATH_FRESH, PH_PATH_OPEN: begin
					if (b == CH_QUESTION) begin
						if (st.phase == PH_PATH_OPEN) begin
							res[n[1:0]] = mk(EV_SEG_END, 8'd0, PART_PATH, ERR_NONE);
							n = n + 3'd1;
						end
						st_n.phase = PH_KEY_FRESH;
					end else if (b == CH_SLASH) begin
						res[n[1:0]] = mk(EV_SEG_END, 8'd0, PART_PATH, ERR_NONE);
						n = n + 3'd1;
						st_n.phase = PH_PATH_OPEN;
					end else if (b == CH_PERCENT) begin
						st_n.phase = PH_PATH_OPEN;
						st_n.esc   = ESC_HIGH;
					end else begin
						st_n.phase = PH_PATH_OPEN;
						res[n[1:0]] = mk(EV_DATA, b, PART_PATH, ERR_NONE);
						n = n + 3'd1;
					end
				end
				PH_KEY_FRESH, PH_KEY_OPEN: begin
					if (b == CH_AMP) begin
						if (st.phase == PH_KEY_OPEN) begin
							res[n[1:0]] = mk(EV_KEY_END, 8'd0, PART_KEY, ERR_NONE);
							n = n + 3'd1;
							res[n[1:0]] = mk(EV_PAIR_END, 8'd0, PART_VALUE, ERR_NONE);
							n = n + 3'd1;
						end
						st_n.phase = PH_KEY_FRESH;
					end else if (b == CH_EQUALS) begin
						res[n[1:0]] = mk(EV_KEY_END, 8'd0, PART_KEY, ERR_NONE);
						n = n + 3'd1;
						st_n.phase = PH_VALUE;
					end else if (b == CH_PERCENT) begin
						st_n.phase = PH_KEY_OPEN;
						st_n.esc   = ESC_HIGH;
					end else begin
						st_n.phase = PH_KEY_OPEN;
						res[n[1:0]] = mk(EV_DATA, b, PART_KEY, ERR_NONE);
						n = n + 3'd1;
					end
				end
				default: begin
					if (b == CH_AMP) begin
						res[n[1:0]] = mk(EV_PAIR_END, 8'd0, PART_VALUE, ERR_NONE);
						n = n + 3'd1;
						st_n.phase = PH_KEY_FRESH;
					end else if (b == CH_PERCENT) begin
						st_n.esc = ESC_HIGH;
					end else begin
						res[n[1:0]] = mk(EV_DATA, b, PART_VALUE, ERR_NONE);
						n = n + 3'd1;
					end
				end
			endcase
		end

		// end of target: close what is open, then accept, or flag an error if an escape is unfinished
		if (do_fin) begin
			if (st_n.esc != ESC_IDLE) begin
				res[n[1:0]] = mk(EV_ERROR, 8'd0, PART_PATH, ERR_ESCAPE);
				n = n + 3'd1;
			end else begin
				if (st_n.phase == PH_PATH_OPEN) begin
					res[n[1:0]] = mk(EV_SEG_END, 8'd0, PART_PATH, ERR_NONE);
					n = n + 3'd1;
				end else if (st_n.phase == PH_KEY_OPEN) begin
					res[n[1:0]] = mk(EV_KEY_END, 8'd0, PART_KEY, ERR_NONE);
					n = n + 3'd1;
					res[n[1:0]] = mk(EV_PAIR_END, 8'd0, PART_VALUE, ERR_NONE);
					n = n + 3'd1;
				end else if (st_n.phase == PH_VALUE) begin
					res[n[1:0]] = mk(EV_PAIR_END, 8'd0, PART_VALUE, ERR_NONE);
					n = n + 3'd1;
				end
				res[n[1:0]] = mk(EV_ACCEPT, 8'd0, PART_PATH, ERR_NONE);
				n = n + 3'd1;
			end
			st_n = ST_RESET;
		end

		grp.cnt = n;
		grp.res = res;
	end

endmodule
